// ===== rtl/pif_command_ram_processor_core_macros.svh =====
// ----------------------------------------------------------------------------
// pif_command_ram_processor_core_macros
// Assertion macros for the command ram processor checks.
// ----------------------------------------------------------------------------
`ifndef PIF_COMMAND_RAM_PROCESSOR_CORE_MACROS_SVH
`define PIF_COMMAND_RAM_PROCESSOR_CORE_MACROS_SVH

// same-cycle implication
`define PIF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pif_pkg.sv =====
// ----------------------------------------------------------------------------
// pif_pkg
// Types and constants shared by the command ram processor files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pif_pkg;

  localparam int RAM_DEPTH = 64;
  localparam int ADDR_W    = 6;

  localparam logic [ADDR_W-1:0] CTRL_IDX = 6'd63;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RUN   = 2'd2;

  localparam logic [5:0] TAG_NEXT_A = 6'h00;
  localparam logic [5:0] TAG_NEXT_B = 6'h3D;
  localparam logic [5:0] TAG_END    = 6'h3E;
  localparam logic [5:0] TAG_SKIP   = 6'h3F;

  localparam logic [7:0] RX_END    = 8'hFE;
  localparam logic [7:0] RX_FORCE  = 8'h80;
  localparam logic [7:0] CTRL_DONE = 8'd128;
  localparam logic [7:0] CTRL_MASK = 8'hF7;

  localparam logic [7:0] CMD_INFO   = 8'd0;
  localparam logic [7:0] CMD_STATUS = 8'd1;
  localparam logic [7:0] CMD_NOP_A  = 8'd2;
  localparam logic [7:0] CMD_NOP_B  = 8'd3;

  localparam logic [7:0] ID_BYTE0 = 8'h05;
  localparam logic [7:0] ID_BYTE1 = 8'h00;
  localparam logic [7:0] ID_BYTE2 = 8'h01;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  address;
    logic [7:0]  write_data;
    logic [31:0] controller_status;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bad_command;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/pif_ram.sv =====
// ----------------------------------------------------------------------------
// pif_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/pif_command_ram_processor_core.sv =====
// write transaction: result offered from S_DONE after acceptance; read: through S_RD, then S_DONE
// run: S_CTRL, an S_TAG step per tag byte walked, S_RX, S_CMD, S_REPLY and S_TAG_REQ per command block,
// then S_FIN, plus S_FIN_RD when control bit 3 is cleared; all steps share the single read and write ram ports
// one transaction at a time; in_ready is high only while the sequencer is idle,
// which waits while an earlier result is still held on the output
// synchronous reset clears control state and the ram valid bits, so every byte reads as zero
// ----------------------------------------------------------------------------
// pif_command_ram_processor_core
// Command ram with byte access and a sequenced command block walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pif_command_ram_processor_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pif_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pif_pkg::out_t      out_data
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD      = 4'd1;
  localparam logic [3:0] S_CTRL    = 4'd2;
  localparam logic [3:0] S_TAG_REQ = 4'd3;
  localparam logic [3:0] S_TAG     = 4'd4;
  localparam logic [3:0] S_RX      = 4'd5;
  localparam logic [3:0] S_CMD     = 4'd6;
  localparam logic [3:0] S_REPLY   = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;
  localparam logic [3:0] S_FIN_RD  = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [5:0]  tag_r, tag_nxt;
  logic [5:0]  rx_r, rx_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        sel_stat_r, sel_stat_nxt;
  logic        cmd_oob_r, cmd_oob_nxt;
  logic        clr3_r, clr3_nxt;
  logic        set128_r, set128_nxt;
  logic [31:0] status_r, status_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        bad_r, bad_nxt;
  logic [pif_pkg::RAM_DEPTH-1:0] vld_r;
  logic        rdv_r;
  logic        out_valid_r;
  pif_pkg::out_t out_data_r;

  logic                       ram_we;
  logic [pif_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic [pif_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                 ram_q;
  logic [7:0]                 rd_byte;
  logic [7:0]                 rx_full;
  logic [7:0]                 op;
  logic [7:0]                 rep_addr;
  logic [7:0]                 rep_byte;
  logic                       in_fire;

  pif_ram #(
    .WIDTH (8),
    .DEPTH (pif_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_byte  = rdv_r ? ram_q : 8'd0;
  assign rx_full  = rd_byte | pif_pkg::RX_FORCE;
  assign op       = cmd_oob_r ? 8'd0 : rd_byte;
  assign rep_addr = pos_r + {5'd0, idx_r};

  always_comb begin
    rep_byte = 8'd0;
    if (sel_stat_r) begin
      case (idx_r[1:0])
        2'd0:    rep_byte = status_r[31:24];
        2'd1:    rep_byte = status_r[23:16];
        2'd2:    rep_byte = status_r[15:8];
        default: rep_byte = status_r[7:0];
      endcase
    end else begin
      case (idx_r[1:0])
        2'd0:    rep_byte = pif_pkg::ID_BYTE0;
        2'd1:    rep_byte = pif_pkg::ID_BYTE1;
        default: rep_byte = pif_pkg::ID_BYTE2;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    tag_nxt      = tag_r;
    rx_nxt       = rx_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    sel_stat_nxt = sel_stat_r;
    cmd_oob_nxt  = cmd_oob_r;
    clr3_nxt     = clr3_r;
    set128_nxt   = set128_r;
    status_nxt   = status_r;
    rd_nxt       = rd_r;
    bad_nxt      = bad_r;
    ram_we       = 1'b0;
    ram_waddr    = in_data.address;
    ram_wdata    = in_data.write_data;
    ram_raddr    = in_data.address;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rd_nxt  = 8'd0;
          bad_nxt = 1'b0;
          case (in_data.action)
            pif_pkg::ACT_WRITE: begin
              ram_we    = 1'b1;
              state_nxt = S_DONE;
            end
            pif_pkg::ACT_READ: begin
              state_nxt = S_RD;
            end
            pif_pkg::ACT_RUN: begin
              ram_raddr  = pif_pkg::CTRL_IDX;
              status_nxt = in_data.controller_status;
              state_nxt  = S_CTRL;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_RD: begin
        rd_nxt    = rd_byte;
        state_nxt = S_DONE;
      end

      S_CTRL: begin
        clr3_nxt   = rd_byte[3];
        set128_nxt = rd_byte[4] | rd_byte[5];
        if (rd_byte[0]) begin
          pos_nxt   = 8'd0;
          ram_raddr = '0;
          state_nxt = S_TAG;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_TAG_REQ: begin
        ram_raddr = pos_r[pif_pkg::ADDR_W-1:0];
        if (pos_r >= {2'b00, pif_pkg::CTRL_IDX}) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_TAG;
        end
      end

      S_TAG: begin
        ram_raddr = pos_r[pif_pkg::ADDR_W-1:0] + 6'd1;
        if (rd_byte[5:0] == pif_pkg::TAG_END) begin
          state_nxt = S_FIN;
        end else if (rd_byte[5:0] == pif_pkg::TAG_NEXT_A ||
                     rd_byte[5:0] == pif_pkg::TAG_NEXT_B ||
                     rd_byte[5:0] == pif_pkg::TAG_SKIP) begin
          pos_nxt = pos_r + 8'd1;
          if (pos_r < 8'd62) begin
            state_nxt = S_TAG;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          tag_nxt   = rd_byte[5:0];
          state_nxt = S_RX;
        end
      end

      S_RX: begin
        ram_raddr   = pos_r[pif_pkg::ADDR_W-1:0] + 6'd2;
        cmd_oob_nxt = (pos_r >= 8'd62);
        rx_nxt      = rx_full[5:0];
        if (rx_full == pif_pkg::RX_END) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CMD;
        end
      end

      S_CMD: begin
        pos_nxt = pos_r + 8'd2 + {2'b00, tag_r};
        idx_nxt = 3'd0;
        case (op)
          pif_pkg::CMD_INFO: begin
            sel_stat_nxt = 1'b0;
            cnt_nxt      = 3'd3;
            state_nxt    = S_REPLY;
          end
          pif_pkg::CMD_STATUS: begin
            sel_stat_nxt = 1'b1;
            cnt_nxt      = 3'd4;
            state_nxt    = S_REPLY;
          end
          pif_pkg::CMD_NOP_A, pif_pkg::CMD_NOP_B: begin
            cnt_nxt   = 3'd0;
            state_nxt = S_REPLY;
          end
          default: begin
            bad_nxt   = 1'b1;
            state_nxt = S_FIN;
          end
        endcase
      end

      S_REPLY: begin
        ram_waddr = rep_addr[pif_pkg::ADDR_W-1:0];
        ram_wdata = rep_byte;
        if (idx_r == cnt_r) begin
          pos_nxt   = pos_r + {2'b00, rx_r};
          state_nxt = S_TAG_REQ;
        end else begin
          ram_we  = (rep_addr[7:6] == 2'b00);
          idx_nxt = idx_r + 3'd1;
        end
      end

      S_FIN: begin
        ram_waddr = pif_pkg::CTRL_IDX;
        ram_wdata = pif_pkg::CTRL_DONE;
        ram_raddr = pif_pkg::CTRL_IDX;
        if (set128_r) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else if (clr3_r) begin
          state_nxt = S_FIN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_FIN_RD: begin
        ram_we    = 1'b1;
        ram_waddr = pif_pkg::CTRL_IDX;
        ram_wdata = rd_byte & pif_pkg::CTRL_MASK;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    tag_r      <= tag_nxt;
    rx_r       <= rx_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    sel_stat_r <= sel_stat_nxt;
    cmd_oob_r  <= cmd_oob_nxt;
    clr3_r     <= clr3_nxt;
    set128_r   <= set128_nxt;
    status_r   <= status_nxt;
    rd_r       <= rd_nxt;
    bad_r      <= bad_nxt;
    rdv_r      <= vld_r[ram_raddr];
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_data_r.read_data   <= rd_r;
      out_data_r.bad_command <= bad_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pif_checker.sv =====
// ----------------------------------------------------------------------------
// pif_checker
// Port-level checks for the command ram processor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pif_command_ram_processor_core_macros.svh"

module pif_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire pif_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire pif_pkg::out_t out_data
);

  `PIF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data), "result dropped or changed while stalled")

  `PIF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready,
    !in_ready, "ready after an accepted transaction")

  `PIF_ASSERT_IMP(a_bad_no_data, clk, rst_n, out_valid && out_data.bad_command,
    out_data.read_data == 8'd0, "bad command result carries read data")

  `PIF_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(out_valid),
    !$past(in_ready), "result appeared without a transaction in flight")

  `PIF_ASSERT_NXT(a_write_no_early, clk, rst_n,
    in_valid && in_ready && in_data.action == pif_pkg::ACT_WRITE,
    !in_ready, "write transaction did not occupy the sequencer")

endmodule

bind pif_command_ram_processor_core pif_checker u_pif_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
